@@ sv/hpdf_pkg.sv @@
// Shared constants, types and the FNV-1a fold step for the duplicate filter.
`timescale 1ns / 1ps
`default_nettype none

package hpdf_pkg;

    localparam int          CACHE_ENTRIES_DEF = 16;
    localparam logic [31:0] FNV_BASIS         = 32'h811C9DC5;
    localparam logic [31:0] FNV_PRIME         = 32'h01000193;
    localparam logic [31:0] TTL_RESET         = 32'd2000;

    // one finished payload waiting for lookup
    typedef struct packed {
        logic [31:0] hash;
        logic [31:0] now;
    } job_t;

    // front -> job queue write
    typedef struct packed {
        logic valid;
        job_t job;
    } job_req_t;

    // job queue status
    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

    function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

`default_nettype wire

@@ sv/hpdf_front.sv @@
// Front end: byte intake and running FNV-1a hash, hands finished payloads to the job queue.
`timescale 1ns / 1ps
`default_nettype none

module hpdf_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [7:0]         data_byte,
    input  logic               last_byte,
    input  logic [31:0]        now_ms,
    input  hpdf_pkg::q_stat_t  q_stat,
    output logic               full,
    output hpdf_pkg::job_req_t job_req
);
    import hpdf_pkg::*;

    logic [31:0] running_hash_reg;
    logic [31:0] running_hash_next;
    logic [31:0] folded;
    logic        accept;

    assign full   = q_stat.full;
    assign accept = push & ~full;
    assign folded = fnv_step(running_hash_reg, data_byte);

    always_comb
    begin
        running_hash_next = running_hash_reg;
        if (accept)
        begin
            running_hash_next = last_byte ? FNV_BASIS : folded;
        end
    end

    assign job_req.valid    = accept & last_byte;
    assign job_req.job.hash = folded;
    assign job_req.job.now  = now_ms;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= FNV_BASIS;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hpdf_jobq.sv @@
// Two-entry queue of finished payload hashes between front and back.
`timescale 1ns / 1ps
`default_nettype none

module hpdf_jobq
(
    input  logic               clk,
    input  logic               rst_n,
    input  hpdf_pkg::job_req_t wr,
    input  logic               rd,
    output hpdf_pkg::job_t     head,
    output hpdf_pkg::q_stat_t  stat
);
    import hpdf_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head       = slot_reg[rd_ptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr.valid)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr.valid && !rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd && !wr.valid)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.valid)
        begin
            slot_reg[wr_ptr_reg] <= wr.job;
        end
    end

endmodule

`default_nettype wire

@@ sv/hpdf_back.sv @@
// Back end: ring lookup by sequential scan, FIFO replacement, TTL register and result register.
`timescale 1ns / 1ps
`default_nettype none

module hpdf_back
#(
    parameter int CACHE_ENTRIES = hpdf_pkg::CACHE_ENTRIES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  hpdf_pkg::job_t    q_head,
    input  hpdf_pkg::q_stat_t q_stat,
    output logic              q_pop,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [31:0]       cfg_data,
    input  logic              pop,
    output logic              empty,
    output logic [31:0]       hash_value,
    output logic              is_duplicate
);
    import hpdf_pkg::*;

    localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } bk_state_t;

    bk_state_t          state_reg;
    bk_state_t          state_next;
    logic [31:0]        ttl_reg;
    job_t               job_reg;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   scan_idx_next;
    logic [IDX_W-1:0]   head_reg;
    logic [IDX_W-1:0]   head_next;
    logic               hit_reg;
    logic               hit_next;
    logic               cmp_en_reg;
    logic [CACHE_ENTRIES-1:0] ring_valid_reg;
    logic [31:0]        ring_hash_mem [CACHE_ENTRIES];
    logic [31:0]        ring_time_mem [CACHE_ENTRIES];
    logic [31:0]        rd_hash_reg;
    logic [31:0]        rd_time_reg;
    logic               rd_live_reg;
    logic               out_valid_reg;
    logic [31:0]        out_hash_reg;
    logic               out_dup_reg;
    logic [31:0]        age;
    logic               match;
    logic               out_room;
    logic               finish;
    logic               store;

    assign cfg_ready    = 1'b1;
    assign empty        = ~out_valid_reg;
    assign hash_value   = out_hash_reg;
    assign is_duplicate = out_dup_reg;

    // age wraps, so a timestamp from the future reads as a large age and matches only if ttl_reg exceeds it
    assign age      = job_reg.now - rd_time_reg;
    assign match    = cmp_en_reg & rd_live_reg & (rd_hash_reg == job_reg.hash) & (age < ttl_reg);
    assign out_room = ~out_valid_reg | pop;
    assign finish   = (state_reg == S_DONE) & out_room;
    assign store    = finish & ~hit_reg;
    assign q_pop    = (state_reg == S_IDLE) & ~q_stat.empty;

    always_comb
    begin
        state_next    = state_reg;
        scan_idx_next = scan_idx_reg;
        hit_next      = hit_reg | match;
        head_next     = head_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next    = S_SCAN;
                    scan_idx_next = '0;
                    hit_next      = 1'b0;
                end
            end
            S_SCAN:
            begin
                if (scan_idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_room)
                begin
                    state_next = S_IDLE;
                end
                if (store)
                begin
                    head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ttl_reg        <= TTL_RESET;
            scan_idx_reg   <= '0;
            head_reg       <= '0;
            hit_reg        <= 1'b0;
            cmp_en_reg     <= 1'b0;
            ring_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            scan_idx_reg <= scan_idx_next;
            head_reg     <= head_next;
            hit_reg      <= hit_next;
            cmp_en_reg   <= (state_reg == S_SCAN);
            if (cfg_valid)
            begin
                ttl_reg <= cfg_data;
            end
            if (store)
            begin
                ring_valid_reg[head_reg] <= 1'b1;
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // job and result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_head;
        end
        if (finish)
        begin
            out_hash_reg <= job_reg.hash;
            out_dup_reg  <= hit_reg;
        end
    end

    // ring storage, one read port for the scan and one write port for replacement
    always_ff @(posedge clk)
    begin
        if (store)
        begin
            ring_hash_mem[head_reg] <= job_reg.hash;
            ring_time_mem[head_reg] <= job_reg.now;
        end
        if (state_reg == S_SCAN)
        begin
            rd_hash_reg <= ring_hash_mem[scan_idx_reg];
            rd_time_reg <= ring_time_mem[scan_idx_reg];
            rd_live_reg <= ring_valid_reg[scan_idx_reg];
        end
    end

    a_head_moves_on_store: assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg != $past(head_reg)) |-> $past(state_reg == S_DONE && !hit_reg))
        else $error("ring head moved without a store");

    a_store_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        store |=> ring_valid_reg[$past(head_reg)])
        else $error("stored slot not marked valid");

    a_cmp_follows_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmp_en_reg |-> $past(state_reg == S_SCAN))
        else $error("compare stage active outside a scan");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result appeared without a finished lookup");

endmodule

`default_nettype wire

@@ sv/hashed_payload_duplicate_filter_core.sv @@
// Top level of the FNV-1a payload duplicate filter.
// Usage:
//   Input queue side: drive data_byte/last_byte/now_ms with push; a byte is taken
//   on a clock edge with push high and full low. now_ms matters only with last_byte.
//   Result queue side: while empty is low, hash_value/is_duplicate hold the oldest
//   result; it is taken on an edge with pop high. One result per payload.
//   Config: ttl_ms is written through cfg_valid/cfg_data (cfg_ready is always high);
//   write it only while no payload is in flight.
// Timing:
//   Ordinary bytes are taken one per cycle while full is low. The final byte queues
//   the payload hash for lookup; the lookup scans the ring one entry per cycle, then
//   goes through a drain state to a done state that fills the result register once
//   it has room. A two-deep job queue lets bytes of following payloads keep
//   arriving meanwhile; full rises only when that queue holds two pending lookups.
// Reset:
//   rst_n clears the running hash to the offset basis, all ring entries to invalid,
//   the ring head to zero and ttl_ms to 2000. No clearing pass is needed.
// Stall:
//   With the result not popped, the back end holds the next finished lookup and
//   stops; the job queue then fills and full stalls the input side.
`timescale 1ns / 1ps
`default_nettype none

module hashed_payload_duplicate_filter_core
#(
    parameter int CACHE_ENTRIES = hpdf_pkg::CACHE_ENTRIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] now_ms,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] hash_value,
    output logic        is_duplicate,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);
    import hpdf_pkg::*;

    job_req_t job_req;
    job_t     q_head;
    q_stat_t  q_stat;
    logic     q_pop;

    hpdf_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .now_ms    (now_ms),
        .q_stat    (q_stat),
        .full      (full),
        .job_req   (job_req)
    );

    hpdf_jobq u_jobq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (job_req),
        .rd    (q_pop),
        .head  (q_head),
        .stat  (q_stat)
    );

    hpdf_back
    #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    )
    u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_head       (q_head),
        .q_stat       (q_stat),
        .q_pop        (q_pop),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .pop          (pop),
        .empty        (empty),
        .hash_value   (hash_value),
        .is_duplicate (is_duplicate)
    );

endmodule

`default_nettype wire
